[hw/rtl/md5sh_pkg.sv]
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types, constants and round functions of the streaming MD5 engine.
// ----------------------------------------------------------------------------
package md5sh_pkg;

    localparam int NUM_ROUNDS  = 64;
    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_WORDS = 16;
    localparam int NUM_BUFS    = 2;
    localparam int REQ_DEPTH   = 2;
    localparam int OUT_DEPTH_DEF = 4;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam logic [31:0] CHAIN_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Byte write into the block store
    typedef struct packed {
        logic       en;
        logic       buf_sel;
        logic [5:0] pos;
        logic [7:0] data;
    } t_wr_req;

    // Full block handed to the compression core
    typedef struct packed {
        logic last;
        logic buf_sel;
    } t_blk_req;

    // Block store released by the core
    typedef struct packed {
        logic valid;
        logic buf_sel;
    } t_blk_done;

    // One digest word
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } t_digest;

    // Message word used by round i
    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] ii;
        logic [3:0] g;
        ii = i[3:0];
        case (i[5:4])
            2'd0:    g = ii;
            2'd1:    g = ii + {ii[1:0], 2'b00} + 4'd1;
            2'd2:    g = ii + {ii[2:0], 1'b0} + 4'd5;
            2'd3:    g = {ii[0], 3'b000} - ii;
            default: g = ii;
        endcase
        return g;
    endfunction

    // Left-rotate amount of round i
    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Nonlinear function of each round group
    function automatic logic [31:0] round_f(input logic [1:0] stage,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        case (stage)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] vv;
        vv = {v, v} << s;
        return vv[63:32];
    endfunction

endpackage

[hw/rtl/md5_stream_hasher.sv]
// ----------------------------------------------------------------------------
// md5_stream_hasher
// Streaming MD5 engine: byte intake with padding, block queue, round core
// and digest word queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_msg_byte / i_byte_valid / i_end_of_message with
//   push; the request is taken on a clock edge with push high and full low.
//   A request with i_byte_valid low carries no byte; i_end_of_message closes
//   the message after the byte (if any) of that request.
//   Output channel: while empty is low the oldest digest word sits on
//   o_digest_word / o_word_index / o_last_word; pop takes it. Each message
//   yields four words, index 0 first, o_last_word on the fourth.
//   Throughput: one byte per cycle while a block buffer is free. Each full
//   block occupies the round core for its 64 rounds, one word fetch and
//   one chaining add, so the core finishes one block before it pops the next.
//   End of message: the padding writes one byte per cycle while a block
//   buffer is free, with full held high; the digest follows once the
//   queued blocks and the last one have passed through the core.
//   Stall: if pop stays low the digest queue fills, the core holds its
//   words, and full rises once both block buffers are in use.
//   Reset (synchronous, active low): chaining words and length reload,
//   both queues empty; the block store itself is not cleared.
// ----------------------------------------------------------------------------
module md5_stream_hasher
    import md5sh_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    localparam int REQ_W = $bits(t_blk_req);
    localparam int OUT_W = $bits(t_digest);

    t_wr_req    wr;
    t_blk_req   req_in;
    t_blk_req   req_out;
    t_blk_done  done;
    t_digest    dig_in;
    t_digest    dig_out;
    logic       req_push;
    logic       req_full;
    logic       req_pop;
    logic       req_empty;
    logic       out_push;
    logic       out_full;
    logic [REQ_W-1:0] req_data;
    logic [OUT_W-1:0] out_data;

    // byte intake and padding
    md5sh_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_msg_byte       (i_msg_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_wr             (wr),
        .o_req_push       (req_push),
        .o_req            (req_in),
        .i_req_full       (req_full),
        .i_done           (done)
    );

    // full blocks waiting for the core
    md5sh_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (REQ_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (req_push),
        .i_data  (req_in),
        .o_full  (req_full),
        .i_pop   (req_pop),
        .o_data  (req_data),
        .o_empty (req_empty)
    );

    assign req_out = t_blk_req'(req_data);

    // compression core
    md5sh_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_req_empty (req_empty),
        .i_req       (req_out),
        .o_req_pop   (req_pop),
        .o_done      (done),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out       (dig_in)
    );

    // digest words toward the receiver
    md5sh_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (dig_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign dig_out       = t_digest'(out_data);
    assign o_digest_word = dig_out.word;
    assign o_word_index  = dig_out.idx;
    assign o_last_word   = dig_out.last;

endmodule

[hw/rtl/md5sh_fifo.sv]
// ----------------------------------------------------------------------------
// md5sh_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module md5sh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hw/rtl/md5sh_front.sv]
// ----------------------------------------------------------------------------
// md5sh_front
// Takes message bytes into the two block buffers, keeps the length count and
// runs the end-of-message padding. Hands each full block to the core.
// ----------------------------------------------------------------------------
module md5sh_front
    import md5sh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  logic [7:0] i_msg_byte,
    input  logic      i_byte_valid,
    input  logic      i_end_of_message,
    output t_wr_req   o_wr,
    output logic      o_req_push,
    output t_blk_req  o_req,
    input  logic      i_req_full,
    input  t_blk_done i_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_PADLEN
    } t_state;

    t_state       r_state, n_state;
    logic [5:0]   r_pos, n_pos;
    logic         r_sel, n_sel;
    logic [1:0]   r_busy, n_busy;
    logic [60:0]  r_byte_cnt, n_byte_cnt;
    logic [63:0]  r_len, n_len;
    logic [2:0]   r_len_cnt, n_len_cnt;

    logic         can_write;
    logic         accept;
    logic         wr_en;
    logic [7:0]   wr_data;
    logic         last_blk;
    logic [5:0]   pos_inc;

    assign can_write = !r_busy[r_sel] && !i_req_full;
    assign o_full    = (r_state != S_IDLE) || !can_write;
    assign accept    = i_push && !o_full;
    assign pos_inc   = r_pos + 6'd1;

    // byte source for the current cycle
    always_comb begin
        wr_en    = 1'b0;
        wr_data  = '0;
        last_blk = 1'b0;
        case (r_state)
            S_IDLE: begin
                wr_en   = accept && i_byte_valid;
                wr_data = i_msg_byte;
            end
            S_PAD80: begin
                wr_en   = can_write;
                wr_data = PAD_BYTE;
            end
            S_PADZ: begin
                wr_en   = can_write;
                wr_data = '0;
            end
            S_PADLEN: begin
                wr_en    = can_write;
                wr_data  = r_len[7:0];
                last_blk = (r_len_cnt == 3'd7);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign o_wr.en      = wr_en;
    assign o_wr.buf_sel = r_sel;
    assign o_wr.pos     = r_pos;
    assign o_wr.data    = wr_data;

    assign o_req_push    = wr_en && (r_pos == LAST_POS);
    assign o_req.last    = last_blk;
    assign o_req.buf_sel = r_sel;

    // next state
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_sel      = r_sel;
        n_busy     = r_busy;
        n_byte_cnt = r_byte_cnt;
        n_len      = r_len;
        n_len_cnt  = r_len_cnt;

        if (i_done.valid) begin
            n_busy[i_done.buf_sel] = 1'b0;
        end
        if (wr_en) begin
            n_pos = pos_inc;
        end
        if (o_req_push) begin
            n_busy[r_sel] = 1'b1;
            n_sel         = !r_sel;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_byte_valid) begin
                        n_byte_cnt = r_byte_cnt + 61'd1;
                    end
                    if (i_end_of_message) begin
                        n_len      = {n_byte_cnt, 3'b000};
                        n_byte_cnt = '0;
                        n_len_cnt  = '0;
                        n_state    = S_PAD80;
                    end
                end
            end
            S_PAD80, S_PADZ: begin
                if (wr_en) begin
                    n_state = (pos_inc == LEN_POS) ? S_PADLEN : S_PADZ;
                end
            end
            S_PADLEN: begin
                if (wr_en) begin
                    n_len     = {8'h00, r_len[63:8]};
                    n_len_cnt = r_len_cnt + 3'd1;
                    if (last_blk) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_sel      <= 1'b0;
            r_busy     <= '0;
            r_byte_cnt <= '0;
            r_len_cnt  <= '0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_sel      <= n_sel;
            r_busy     <= n_busy;
            r_byte_cnt <= n_byte_cnt;
            r_len_cnt  <= n_len_cnt;
        end
        r_len <= n_len;
    end

`ifndef SYNTHESIS
    // never write into a buffer the core still owns
    a_wr_free_buf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !r_busy[r_sel])
        else $error("front wrote a busy block buffer");

    // length bytes always land in the last eight slots
    a_len_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PADLEN) |-> (r_pos[5:3] == 3'b111))
        else $error("length bytes outside tail of block");

    // padding ends on a block boundary and returns to byte intake
    a_pad_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PADLEN && wr_en && r_len_cnt == 3'd7)
            |=> (r_state == S_IDLE && r_pos == '0))
        else $error("padding did not end on a block boundary");
`endif

endmodule

[hw/rtl/md5sh_core.sv]
// ----------------------------------------------------------------------------
// md5sh_core
// Holds the double-buffered block store and runs the MD5 compression, one
// round per cycle. Emits the chaining words after the final block.
// ----------------------------------------------------------------------------
module md5sh_core
    import md5sh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_wr_req   i_wr,
    input  logic      i_req_empty,
    input  t_blk_req  i_req,
    output logic      o_req_pop,
    output t_blk_done o_done,
    input  logic      i_out_full,
    output logic      o_out_push,
    output t_digest   o_out
);

    localparam int MEM_WORDS = NUM_BUFS * BLOCK_WORDS;
    localparam int MAW       = $clog2(MEM_WORDS);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_FINAL,
        C_EMIT
    } t_state;

    // block store: word address is {buffer, word}, bytes little-endian
    logic [31:0]    r_mem [MEM_WORDS];
    logic [31:0]    r_rdata;
    logic [MAW-1:0] raddr;

    t_state      r_state;
    t_blk_req    r_cur;
    logic [5:0]  r_rnd;
    logic [1:0]  r_idx;
    logic [31:0] r_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;

    logic [5:0]  rnd_next;
    logic [31:0] f_val;
    logic [31:0] t_val;
    logic [31:0] b_new;

    // one MD5 round on the registered working words
    assign rnd_next = r_rnd + 6'd1;
    assign f_val    = round_f(r_rnd[5:4], r_b, r_c, r_d);
    assign t_val    = r_a + f_val + r_rdata + ROUND_K[r_rnd];
    assign b_new    = r_b + rotl32(t_val, rot_amt(r_rnd));

    // read address: prefetch the word for the next round
    always_comb begin
        if (r_state == C_IDLE) begin
            raddr = {i_req.buf_sel, msg_index(6'd0)};
        end else begin
            raddr = {r_cur.buf_sel, msg_index(rnd_next)};
        end
    end

    // block store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.buf_sel, i_wr.pos[5:2]}][{i_wr.pos[1:0], 3'b000} +: 8] <= i_wr.data;
        end
        r_rdata <= r_mem[raddr];
    end

    assign o_req_pop      = (r_state == C_IDLE) && !i_req_empty;
    assign o_done.valid   = (r_state == C_FINAL);
    assign o_done.buf_sel = r_cur.buf_sel;
    assign o_out_push     = (r_state == C_EMIT) && !i_out_full;
    assign o_out.word     = r_chain[r_idx];
    assign o_out.idx      = r_idx;
    assign o_out.last     = (r_idx == 2'd3);

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_rnd   <= '0;
            r_idx   <= '0;
            r_cur   <= '0;
            for (int k = 0; k < 4; k++) begin
                r_chain[k] <= CHAIN_INIT[k];
            end
        end else begin
            case (r_state)
                C_IDLE: begin
                    if (o_req_pop) begin
                        r_cur   <= i_req;
                        r_rnd   <= '0;
                        r_a     <= r_chain[0];
                        r_b     <= r_chain[1];
                        r_c     <= r_chain[2];
                        r_d     <= r_chain[3];
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    r_a   <= r_d;
                    r_b   <= b_new;
                    r_c   <= r_b;
                    r_d   <= r_c;
                    r_rnd <= rnd_next;
                    if (r_rnd == 6'(NUM_ROUNDS - 1)) begin
                        r_state <= C_FINAL;
                    end
                end
                C_FINAL: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    r_idx      <= '0;
                    r_state    <= r_cur.last ? C_EMIT : C_IDLE;
                end
                C_EMIT: begin
                    if (o_out_push) begin
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            for (int k = 0; k < 4; k++) begin
                                r_chain[k] <= CHAIN_INIT[k];
                            end
                            r_state <= C_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a popped request starts at round zero
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_pop |=> (r_state == C_ROUND && r_rnd == '0))
        else $error("block start did not enter round zero");

    // exactly 64 rounds, then the chaining add
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_ROUND && r_rnd == 6'(NUM_ROUNDS - 1)) |=> (r_state == C_FINAL))
        else $error("round counter overran");

    // buffer release is followed by idle or digest output
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done.valid |=> (r_state == C_IDLE || r_state == C_EMIT))
        else $error("unexpected state after block release");
`endif

endmodule
